// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Fixed-delay implication, ignored while reset is high.
`define ASSERT_DELAY(label, clk, rst, ante, dly, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/hprl_pkg.sv -----
package hprl_pkg;

  localparam int LEVEL_W       = 4;
  localparam int PIX_W         = 30;
  localparam int RING_W        = 15;
  localparam int POS_W         = 16;
  localparam int MAX_LEVEL_DEF = 13;
  // width of the intermediate sums on pixel counts
  localparam int CALC_W        = 32;

endpackage

// ----- rtl/core/healpix_ring_pixel_locator.sv -----
// Channel   Direction  Handshake          Word
// config    in         cfg_we             cfg_wdata (level)
// pixel     in         start, busy        pixel_index
// result    out        done (one cycle)   ring_number, pixel_in_ring, valid_res
//
// One word is taken every cycle; busy is always low.
// From accept to done a word passes the input register, region decode, one
// stage per two root bits of the cap square root, the r*(r-1) multiply, then
// the output register.
// rst is synchronous and clears the level register and every stage valid bit.
// The receiver cannot stall, so the pipeline never holds.

module healpix_ring_pixel_locator #(
  parameter int MAX_LEVEL = hprl_pkg::MAX_LEVEL_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [hprl_pkg::LEVEL_W-1:0] cfg_wdata,
  input  logic                         start,
  output logic                         busy,
  input  logic [hprl_pkg::PIX_W-1:0]   pixel_index,
  output logic                         done,
  output logic [hprl_pkg::RING_W-1:0]  ring_number,
  output logic [hprl_pkg::POS_W-1:0]   pixel_in_ring,
  output logic                         valid_res
);
  import hprl_pkg::*;

  `include "assert_macros.svh"

  localparam int SQ_STG = (MAX_LEVEL + 2) / 2;
  localparam int SQ_IT  = 2 * SQ_STG;
  localparam int RAD_W  = 2 * SQ_IT;
  localparam int ROOT_W = SQ_IT;
  localparam int REM_W  = SQ_IT + 3;
  localparam int LAT    = SQ_STG + 4;

  typedef enum logic [1:0] {REG_NONE, REG_NORTH, REG_BELT, REG_SOUTH} region_t;

  typedef struct packed {
    logic                vld;
    region_t             region;
    logic [LEVEL_W-1:0]  lvl;
    logic [RAD_W-1:0]    a;
    logic [RING_W-1:0]   b_ring;
    logic [POS_W-1:0]    b_pos;
    logic [RAD_W-1:0]    rad;
    logic [REM_W-1:0]    rem;
    logic [ROOT_W-1:0]   root;
  } sq_t;

  typedef struct packed {
    logic                vld;
    region_t             region;
    logic [LEVEL_W-1:0]  lvl;
    logic [RAD_W-1:0]    a;
    logic [RING_W-1:0]   b_ring;
    logic [POS_W-1:0]    b_pos;
    logic [ROOT_W-1:0]   r;
    logic [2*ROOT_W-1:0] prod;
  } mul_t;

  logic [LEVEL_W-1:0] level;
  logic               in_vld;
  logic [PIX_W-1:0]   in_pix;
  logic [LEVEL_W-1:0] in_lvl;

  sq_t  cls;
  sq_t  sq      [0:SQ_STG];
  sq_t  sq_next [1:SQ_STG];
  mul_t mul;
  mul_t mul_next;

  logic [RING_W-1:0] ring_next;
  logic [POS_W-1:0]  pos_next;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
    end else if (cfg_we) begin
      level <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    in_pix <= pixel_index;
    in_lvl <= level;
    if (rst) begin
      in_vld <= 1'b0;
    end else begin
      in_vld <= start && !busy;
    end
  end

  // region decode, belt result and square root operand
  always_comb begin
    logic [CALC_W-1:0] pix_ext, npix, ncap, back, q, mask, nside;
    logic [5:0]        sh_npix, sh_ncap;
    logic [4:0]        sh_n2, sh_n4;
    logic              lvl_ok;
    pix_ext = CALC_W'(in_pix);
    sh_npix = {1'b0, in_lvl, 1'b0} + 6'd2;
    sh_ncap = {1'b0, in_lvl, 1'b0} + 6'd1;
    sh_n2   = {1'b0, in_lvl} + 5'd1;
    sh_n4   = {1'b0, in_lvl} + 5'd2;
    lvl_ok  = int'(in_lvl) <= MAX_LEVEL;
    nside   = CALC_W'(1) << in_lvl;
    npix    = CALC_W'(3) << sh_npix;
    ncap    = (CALC_W'(1) << sh_ncap) - (CALC_W'(1) << sh_n2);
    mask    = (CALC_W'(1) << sh_n4) - CALC_W'(1);
    back    = npix - pix_ext;
    q       = pix_ext - ncap;

    cls        = '0;
    cls.vld    = in_vld;
    cls.lvl    = in_lvl;
    cls.b_ring = RING_W'((q >> sh_n4) + nside);
    cls.b_pos  = POS_W'((q & mask) + CALC_W'(1));
    priority if (!lvl_ok || pix_ext >= npix) begin
      cls.region = REG_NONE;
    end else if (pix_ext < ncap) begin
      cls.region = REG_NORTH;
      cls.a      = RAD_W'(pix_ext);
      cls.rad    = RAD_W'((pix_ext << 1) | CALC_W'(1));
    end else if (pix_ext < npix - ncap) begin
      cls.region = REG_BELT;
    end else begin
      cls.region = REG_SOUTH;
      cls.a      = RAD_W'(back);
      cls.rad    = RAD_W'((back << 1) - CALC_W'(1));
    end
  end

  // two root bits per stage
  always_comb begin
    sq_t              cur;
    logic [REM_W-1:0] rem_s, trial;
    for (int k = 1; k <= SQ_STG; k++) begin
      cur = sq[k-1];
      for (int j = 0; j < 2; j++) begin
        rem_s   = {cur.rem[REM_W-3:0], cur.rad[RAD_W-1 -: 2]};
        cur.rad = cur.rad << 2;
        trial   = REM_W'({cur.root, 2'b01});
        if (rem_s >= trial) begin
          cur.rem  = rem_s - trial;
          cur.root = {cur.root[ROOT_W-2:0], 1'b1};
        end else begin
          cur.rem  = rem_s;
          cur.root = {cur.root[ROOT_W-2:0], 1'b0};
        end
      end
      sq_next[k] = cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= SQ_STG; k++) begin
        sq[k].vld <= 1'b0;
      end
    end else begin
      sq[0] <= cls;
      for (int k = 1; k <= SQ_STG; k++) begin
        sq[k] <= sq_next[k];
      end
    end
  end

  // ring in the cap and its pixel offset
  always_comb begin
    logic [ROOT_W:0]     r1;
    logic [2*ROOT_W-1:0] r_w;
    r1              = {1'b0, sq[SQ_STG].root} + (ROOT_W+1)'(1);
    r_w             = (2*ROOT_W)'(r1[ROOT_W:1]);
    mul_next.vld    = sq[SQ_STG].vld;
    mul_next.region = sq[SQ_STG].region;
    mul_next.lvl    = sq[SQ_STG].lvl;
    mul_next.a      = sq[SQ_STG].a;
    mul_next.b_ring = sq[SQ_STG].b_ring;
    mul_next.b_pos  = sq[SQ_STG].b_pos;
    mul_next.r      = r1[ROOT_W:1];
    mul_next.prod   = r_w * (r_w - (2*ROOT_W)'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul.vld <= 1'b0;
    end else begin
      mul <= mul_next;
    end
  end

  always_comb begin
    logic [CALC_W-1:0] a_ext, r_ext, p2, n4;
    logic [4:0]        sh_n4;
    sh_n4 = {1'b0, mul.lvl} + 5'd2;
    a_ext = CALC_W'(mul.a);
    r_ext = CALC_W'(mul.r);
    p2    = CALC_W'(mul.prod) << 1;
    n4    = CALC_W'(1) << sh_n4;
    unique case (mul.region)
      REG_NORTH: begin
        ring_next = RING_W'(r_ext);
        pos_next  = POS_W'(a_ext + CALC_W'(1) - p2);
      end
      REG_BELT: begin
        ring_next = mul.b_ring;
        pos_next  = mul.b_pos;
      end
      REG_SOUTH: begin
        ring_next = RING_W'(n4 - r_ext);
        pos_next  = POS_W'((r_ext << 2) + CALC_W'(1) - a_ext + p2);
      end
      default: begin
        ring_next = '0;
        pos_next  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    ring_number   <= ring_next;
    pixel_in_ring <= pos_next;
    valid_res     <= mul.region != REG_NONE;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= mul.vld;
    end
  end

  `ASSERT_DELAY(a_fixed_latency, clk, rst, start && !busy, LAT, done,
    "accepted word did not come out after the pipeline latency")

  `ASSERT_IMPLY(a_invalid_zero, clk, rst, done && !valid_res,
    ring_number == '0 && pixel_in_ring == '0,
    "invalid word carries a non-zero ring or position")

  `ASSERT_IMPLY(a_valid_nonzero, clk, rst, done && valid_res,
    ring_number != '0 && pixel_in_ring != '0,
    "valid word has a zero ring or position")

endmodule
